### src/mrc_pkg.sv
// shared types and constants for the matrix rotate clockwise unit
package mrc_pkg;

  localparam int MAX_DIM_DEFAULT    = 32;
  localparam int ELEM_WIDTH_DEFAULT = 32;
  localparam int DATA_W             = 32;
  localparam int CFG_W              = 6;
  localparam int CFG_INDEX_W        = 1;
  localparam int DIM_RESET          = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'b1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] element_in;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] element_out;
    logic              last_element;
    logic              matrix_complete;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic read;
  } ctrl_cmd_t;

  typedef struct packed {
    logic read_req;
  } dp_status_t;

endpackage

### src/mrc_ctrl.sv
// controller state machine: sequences load and read transfers
module mrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  output logic                result_valid,
  input  logic                result_stall,
  input  mrc_pkg::dp_status_t status,
  output mrc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t state;
  logic   take;

  assign take      = item_valid && !item_stall;
  assign cmd.load  = take && !status.read_req;
  assign cmd.read  = take && status.read_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      item_stall   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take && status.read_req) begin
            state        <= S_RESULT;
            item_stall   <= 1'b1;
            result_valid <= 1'b1;
          end
        end
        S_RESULT: begin
          if (!result_stall) begin
            state        <= S_IDLE;
            item_stall   <= 1'b0;
            result_valid <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

### src/mrc_datapath.sv
// datapath: shape registers, position counters, matrix memory and result register
module mrc_datapath #(
  parameter int MAX_DIM    = mrc_pkg::MAX_DIM_DEFAULT,
  parameter int ELEM_WIDTH = mrc_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0]       cfg_data,
  input  mrc_pkg::in_item_t               item,
  input  mrc_pkg::ctrl_cmd_t              cmd,
  output mrc_pkg::dp_status_t             status,
  output mrc_pkg::out_item_t              result
);

  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W   = (mrc_pkg::CFG_W > DIM_W) ? mrc_pkg::CFG_W : DIM_W;
  localparam int RST_DIM = (mrc_pkg::DIM_RESET < MAX_DIM) ? mrc_pkg::DIM_RESET : MAX_DIM;
  localparam logic [IDX_W-1:0] RST_M1 = IDX_W'(RST_DIM - 1);
  localparam logic [IDX_W-1:0] TOP_M1 = IDX_W'(MAX_DIM - 1);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data;

  logic [IDX_W-1:0] rows_m1;
  logic [IDX_W-1:0] cols_m1;
  logic [IDX_W-1:0] load_row;
  logic [IDX_W-1:0] load_col;
  logic [IDX_W-1:0] read_row;
  logic [IDX_W-1:0] read_col;
  logic             full_loaded;
  logic             last_element;
  logic             matrix_complete;

  logic [CMP_W-1:0] cfg_ext;
  logic [IDX_W-1:0] cfg_m1;
  logic [IDX_W-1:0] src_row;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             last_now;

  // clamp the written dimension to 1..MAX_DIM, held as dimension minus one
  always_comb begin
    cfg_ext = CMP_W'(cfg_data);
    priority if (cfg_ext == '0) begin
      cfg_m1 = '0;
    end else if (cfg_ext > CMP_W'(MAX_DIM)) begin
      cfg_m1 = TOP_M1;
    end else begin
      cfg_m1 = IDX_W'(cfg_ext - CMP_W'(1));
    end
  end

  assign status.read_req = (item.operation == mrc_pkg::OP_READ);

  assign src_row  = rows_m1 - read_col;
  assign waddr    = AW'(load_row) * AW'(MAX_DIM) + AW'(load_col);
  assign raddr    = AW'(src_row) * AW'(MAX_DIM) + AW'(read_row);
  assign last_now = (read_row == cols_m1) && (read_col == rows_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m1     <= RST_M1;
      cols_m1     <= RST_M1;
      load_row    <= '0;
      load_col    <= '0;
      read_row    <= '0;
      read_col    <= '0;
      full_loaded <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mrc_pkg::REG_ROW_COUNT: rows_m1 <= cfg_m1;
        mrc_pkg::REG_COL_COUNT: cols_m1 <= cfg_m1;
      endcase
      load_row    <= '0;
      load_col    <= '0;
      read_row    <= '0;
      read_col    <= '0;
      full_loaded <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (load_col == cols_m1) begin
          load_col <= '0;
          if (load_row == rows_m1) begin
            load_row    <= '0;
            full_loaded <= 1'b1;
          end else begin
            load_row <= load_row + IDX_W'(1);
          end
        end else begin
          load_col <= load_col + IDX_W'(1);
        end
      end
      if (cmd.read) begin
        if (read_col == rows_m1) begin
          read_col <= '0;
          if (read_row == cols_m1) begin
            read_row <= '0;
          end else begin
            read_row <= read_row + IDX_W'(1);
          end
        end else begin
          read_col <= read_col + IDX_W'(1);
        end
      end
    end
  end

  // matrix memory, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[waddr] <= ELEM_WIDTH'(item.element_in);
    end
    if (cmd.read) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      last_element    <= last_now;
      matrix_complete <= full_loaded;
    end
  end

  assign result.element_out     = mrc_pkg::DATA_W'(rd_data);
  assign result.last_element    = last_element;
  assign result.matrix_complete = matrix_complete;

endmodule

### src/matrix_rotate_clockwise_unit.sv
// top level of the matrix rotate clockwise unit
// Stores a row_count by col_count matrix loaded element by element in row-major
// order and returns it rotated 90 degrees clockwise, one element per read, as a
// col_count by row_count matrix in row-major order. A load transfer does not
// stall the input, so the next item can follow at once. A read's result is
// offered in the cycle right after the read transfer (the memory read is
// registered), and no new item is taken until that result transfers. Writing
// either shape register restarts the load and read positions and clears the
// loaded flag that the next read reports as matrix_complete.
module matrix_rotate_clockwise_unit #(
  parameter int MAX_DIM    = mrc_pkg::MAX_DIM_DEFAULT,
  parameter int ELEM_WIDTH = mrc_pkg::ELEM_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [mrc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mrc_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  mrc_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output mrc_pkg::out_item_t              result
);

  mrc_pkg::ctrl_cmd_t  cmd;
  mrc_pkg::dp_status_t status;

  mrc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  mrc_datapath #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

### tb/sv/matrix_rotate_clockwise_unit_tb.sv
// testbench for the matrix rotate clockwise unit: directed table, then random shapes
module matrix_rotate_clockwise_unit_tb;
  import mrc_pkg::*;

  localparam int DIM = MAX_DIM_DEFAULT;
  localparam int STORE_DEPTH = DIM * DIM;
  localparam int TOTAL_ITEMS = 1470;
  localparam int QUIET_FROM = 1280;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [1:0] {
    STEP_CFG,
    STEP_ITEM,
    STEP_CHECKED
  } step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_W-1:0]       reg_val;
    op_t                    op;
    logic [DATA_W-1:0]      data;
    out_item_t              want;
  } step_t;

  localparam out_item_t NO_WANT = '0;
  localparam int N_DIRECTED = 28;

  // 2x3 load and full read with wrap, then 1x1 from zero registers, then 1x32 from 63
  step_t directed_steps [N_DIRECTED] = '{
    '{STEP_CFG,     REG_ROW_COUNT, 6'd2,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_CFG,     REG_COL_COUNT, 6'd3,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'hFFFF_FFFF, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h8000_0000, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h0000_0001, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h7FFF_FFFF, NO_WANT},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'hA5A5_A5A5, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'hFFFF_FFFF, '{32'h0000_0001, 1'b0, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h0000_0000, 1'b0, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'hFFFF_FFFF, '{32'h7FFF_FFFF, 1'b0, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'hFFFF_FFFF, 1'b0, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'hFFFF_FFFF, '{32'hA5A5_A5A5, 1'b0, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h8000_0000, 1'b1, 1'b1}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'hFFFF_FFFF, '{32'h0000_0001, 1'b0, 1'b1}},
    '{STEP_CFG,     REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_CFG,     REG_COL_COUNT, 6'd0,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h0000_0000, 1'b1, 1'b0}},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h1234_5678, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h1234_5678, 1'b1, 1'b1}},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'h5A5A_5A5A, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h5A5A_5A5A, 1'b1, 1'b1}},
    '{STEP_CFG,     REG_ROW_COUNT, 6'd1,  OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_CFG,     REG_COL_COUNT, 6'd63, OP_LOAD, 32'h0000_0000, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h5A5A_5A5A, 1'b0, 1'b0}},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{STEP_ITEM,    REG_ROW_COUNT, 6'd0,  OP_LOAD, 32'hDEAD_BEEF, NO_WANT},
    '{STEP_CHECKED, REG_ROW_COUNT, 6'd0,  OP_READ, 32'h0000_0000, '{32'h8000_0000, 1'b0, 1'b0}}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  in_item_t               item = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_item_t              result;

  logic [DATA_W-1:0] store_img [STORE_DEPTH];
  bit                store_written [STORE_DEPTH];
  int unsigned       ld_row, ld_col, rd_row, rd_col;
  bit                loaded_full;
  logic [CFG_W-1:0]  row_reg = CFG_W'(DIM_RESET);
  logic [CFG_W-1:0]  col_reg = CFG_W'(DIM_RESET);

  out_item_t pending_rotated [$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  bit        quiet = 1'b0;

  matrix_rotate_clockwise_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM) return DIM;
    return 32'(v);
  endfunction

  function automatic bit read_source_ready();
    return store_written[(eff_dim(row_reg) - 1 - rd_col) * DIM + rd_row];
  endfunction

  function automatic bit predict_rotation(input in_item_t it, output out_item_t res);
    int unsigned rows, cols, src;
    rows = eff_dim(row_reg);
    cols = eff_dim(col_reg);
    res = '0;
    if (op_t'(it.operation) == OP_LOAD) begin
      store_img[ld_row * DIM + ld_col] = it.element_in;
      store_written[ld_row * DIM + ld_col] = 1'b1;
      ld_col++;
      if (ld_col >= cols) begin
        ld_col = 0;
        ld_row++;
        if (ld_row >= rows) begin
          ld_row = 0;
          loaded_full = 1'b1;
        end
      end
      return 1'b0;
    end
    // output (r, c) comes from input (rows-1-c, r)
    src = (rows - 1 - rd_col) * DIM + rd_row;
    res.element_out = store_img[src];
    res.last_element = (rd_row == cols - 1) && (rd_col == rows - 1);
    res.matrix_complete = loaded_full;
    rd_col++;
    if (rd_col >= rows) begin
      rd_col = 0;
      rd_row++;
      if (rd_row >= cols) rd_row = 0;
    end
    return 1'b1;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return CFG_W'($urandom_range(0, 6));
    if (r < 17) return CFG_W'($urandom_range(7, 32));
    return CFG_W'($urandom_range(33, 63));
  endfunction

  task automatic send_item(input op_t op, input logic [DATA_W-1:0] data, input bit typed,
                           input out_item_t typed_want);
    in_item_t  it;
    out_item_t pred;
    it.operation = op;
    it.element_in = data;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
    if (predict_rotation(it, pred)) pending_rotated.push_back(typed ? typed_want : pred);
  endtask

  // wait until every read has returned and the block is quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_rotated.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ROW_COUNT: row_reg = val;
      default:       col_reg = val;
    endcase
    ld_row = 0;
    ld_col = 0;
    rd_row = 0;
    rd_col = 0;
    loaded_full = 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_rotated.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: element %h last %b complete %b",
                   result.element_out, result.last_element, result.matrix_complete);
      end else begin
        want = pending_rotated.pop_front();
        if (result.element_out !== want.element_out ||
            result.last_element !== want.last_element ||
            result.matrix_complete !== want.matrix_complete) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %h/%b/%b got %h/%b/%b",
                     want.element_out, want.last_element, want.matrix_complete,
                     result.element_out, result.last_element, result.matrix_complete);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("matrix_rotate_clockwise_unit_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      phase_no, total, extra;
    logic [CFG_W-1:0] rv, cv;
    bit               well_formed;
    phase_no = 0;
    ld_row = 0;
    ld_col = 0;
    rd_row = 0;
    rd_col = 0;
    loaded_full = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].kind == STEP_CFG) begin
        settle();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_item(directed_steps[i].op, directed_steps[i].data,
                  directed_steps[i].kind == STEP_CHECKED, directed_steps[i].want);
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      // tall column first, so the full-size shape can read its first output row at once
      case (phase_no)
        0:       begin rv = 6'd33; cv = 6'd1;  end
        1:       begin rv = 6'd63; cv = 6'd63; end
        2:       begin rv = 6'd1;  cv = 6'd32; end
        default: begin rv = pick_dim(); cv = pick_dim(); end
      endcase
      settle();
      if (items_sent >= QUIET_FROM) quiet <= 1'b1;
      if (phase_no < 3 || $urandom_range(0, 2) == 0) begin
        write_reg(REG_ROW_COUNT, rv);
        write_reg(REG_COL_COUNT, cv);
      end else if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_ROW_COUNT, rv);
      end else begin
        write_reg(REG_COL_COUNT, cv);
      end
      total = eff_dim(row_reg) * eff_dim(col_reg);
      well_formed = (phase_no == 0 || phase_no == 2 ||
                     (total <= 48 && $urandom_range(0, 3) != 0));
      if (well_formed) begin
        repeat ($urandom_range(1, 2)) begin
          repeat (total) send_item(OP_LOAD, $urandom(), 1'b0, NO_WANT);
          extra = $urandom_range(0, 2);
          repeat (total + extra) send_item(OP_READ, $urandom(), 1'b0, NO_WANT);
        end
      end else begin
        repeat (phase_no == 1 ? 150 : $urandom_range(10, 60)) begin
          if ($urandom_range(0, 1) == 1 && read_source_ready())
            send_item(OP_READ, $urandom(), 1'b0, NO_WANT);
          else
            send_item(OP_LOAD, $urandom(), 1'b0, NO_WANT);
        end
      end
      phase_no++;
    end

    settle();
    if (mismatch_count == 0 && pending_rotated.size() == 0) begin
      $display("matrix_rotate_clockwise_unit_tb passed");
    end else begin
      $display("matrix_rotate_clockwise_unit_tb failed");
    end
    $finish;
  end

endmodule
